[design/s2lab_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// s2lab_pkg
// Shared types, fixed-point constants and the sRGB decode table for the
// sRGB to CIELAB converter.
// ----------------------------------------------------------------------------
package s2lab_pkg;

  localparam int OUT_FRAC_BITS = 8;
  localparam int RND_SH        = 16 - OUT_FRAC_BITS;

  localparam int CH_W   = 8;
  localparam int LIN_W  = 25;
  localparam int SUM_W  = 38;
  localparam int NUM_W  = 41;
  localparam int NRM_W  = 25;
  localparam int F_W    = 17;
  localparam int L_W    = 15;
  localparam int AB_W   = 16;
  localparam int RAW_W  = 27;
  localparam int LANES  = 3;

  typedef logic [CH_W-1:0]         ch_t;
  typedef logic [LIN_W-1:0]        lin_t;
  typedef logic [SUM_W-1:0]        sum_t;
  typedef logic [NRM_W-1:0]        nrm_t;
  typedef logic [F_W-1:0]          f_t;
  typedef logic [L_W-1:0]          light_t;
  typedef logic signed [AB_W-1:0]  ab_t;
  typedef lin_t                    lin_tbl_t [256];

  localparam longint LIGHT_CAP_RAW = 64'sd100 <<< OUT_FRAC_BITS;
  localparam light_t LIGHT_CAP     = L_W'((LIGHT_CAP_RAW > 64'sd32767) ?
                                          64'sd32767 : LIGHT_CAP_RAW);

  // sRGB to XYZ matrix, units of 1/10000
  localparam logic [13:0] M_XR = 14'd4124, M_XG = 14'd3576, M_XB = 14'd1805;
  localparam logic [13:0] M_YR = 14'd2126, M_YG = 14'd7152, M_YB = 14'd722;
  localparam logic [13:0] M_ZR = 14'd193,  M_ZG = 14'd1192, M_ZB = 14'd9505;

  // White-point normalization: q = floor(n / D), estimated from the top bits
  localparam logic [24:0] DIV_NRM  [LANES] = '{25'd95047, 25'd10000, 25'd108883};
  localparam logic [31:0] RCP_NRM  [LANES] = '{
    32'((64'd1 << 48) / 64'd95047),
    32'((64'd1 << 45) / 64'd10000),
    32'((64'd1 << 48) / 64'd108883)};
  localparam int          DROP_NRM [LANES] = '{16, 13, 16};
  localparam logic [16:0] HALF_X = 17'd47523;
  localparam logic [16:0] HALF_Y = 17'd5000;
  localparam logic [16:0] HALF_Z = 17'd54441;

  // Linear toe of f
  localparam int          TN_W    = 39;
  localparam logic [24:0] T_TOE   = 25'((64'd8856 << 24) / 64'd1000000);
  localparam logic [19:0] F_SLOPE = 20'd903292;
  localparam logic [TN_W-1:0] F_OFS = TN_W'(64'd16000 * 64'd16777216 + 64'd14848000);
  localparam logic [24:0] DIV_F   = 25'd29696000;
  localparam logic [31:0] RCP_F   = 32'((64'd1 << 48) / 64'd29696000);
  localparam int          DROP_F  = 16;

  // sRGB decode: 8-bit code to linear Q24, built at elaboration
  function automatic lin_tbl_t lin_table();
    lin_tbl_t         tb;
    longint unsigned  t, t2, lo, hi, mid, p;
    for (int c = 0; c < 256; c++) begin
      if (c <= 10) begin
        tb[c] = LIN_W'((64'(c) * 64'd1677721600 + 64'd164730) / 64'd329460);
      end else begin
        t  = ((64'd1000 * 64'(c) + 64'd14025) * 64'd16777216 + 64'd134512) / 64'd269025;
        t2 = (t * t) >> 24;
        lo = 0;
        hi = 64'd16777216;
        while (lo < hi) begin
          mid = (lo + hi + 64'd1) >> 1;
          p   = mid;
          for (int k = 0; k < 4; k++) p = (p * mid) >> 24;
          if (p <= t2) lo = mid;
          else         hi = mid - 64'd1;
        end
        tb[c] = LIN_W'((t2 * lo) >> 24);
      end
    end
    return tb;
  endfunction

  localparam lin_tbl_t LIN_TBL = lin_table();

endpackage
`default_nettype wire

[design/s2lab_pix_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// s2lab_pix_if
// Pixel channel: valid/ready with one 8-bit sRGB pixel.
// ----------------------------------------------------------------------------
interface s2lab_pix_if;
  logic              valid;
  logic              ready;
  s2lab_pkg::ch_t    red;
  s2lab_pkg::ch_t    green;
  s2lab_pkg::ch_t    blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface
`default_nettype wire

[design/s2lab_lab_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// s2lab_lab_if
// Result channel: valid/ready with one CIELAB triple.
// ----------------------------------------------------------------------------
interface s2lab_lab_if;
  logic                valid;
  logic                ready;
  s2lab_pkg::light_t   lightness;
  s2lab_pkg::ab_t      green_red;
  s2lab_pkg::ab_t      blue_yellow;

  modport source (output valid, lightness, green_red, blue_yellow, input ready);
  modport sink   (input valid, lightness, green_red, blue_yellow, output ready);
endinterface
`default_nettype wire

[design/s2lab_linxyz.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// s2lab_linxyz
// Gamma decode by table, then the RGB to XYZ matrix. Two stages.
// ----------------------------------------------------------------------------
module s2lab_linxyz (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                en,
  input  wire                in_valid,
  input  s2lab_pkg::ch_t     red,
  input  s2lab_pkg::ch_t     green,
  input  s2lab_pkg::ch_t     blue,
  output logic               out_valid,
  output s2lab_pkg::sum_t    sx,
  output s2lab_pkg::sum_t    sy,
  output s2lab_pkg::sum_t    sz
);
  import s2lab_pkg::*;

  lin_t        lr_r, lg_r, lb_r;
  logic        v1_r, v2_r;
  sum_t        sx_r, sy_r, sz_r;
  sum_t        sx_nxt, sy_nxt, sz_nxt;

  always_comb begin
    sx_nxt = SUM_W'(lr_r) * SUM_W'(M_XR) + SUM_W'(lg_r) * SUM_W'(M_XG)
           + SUM_W'(lb_r) * SUM_W'(M_XB);
    sy_nxt = SUM_W'(lr_r) * SUM_W'(M_YR) + SUM_W'(lg_r) * SUM_W'(M_YG)
           + SUM_W'(lb_r) * SUM_W'(M_YB);
    sz_nxt = SUM_W'(lr_r) * SUM_W'(M_ZR) + SUM_W'(lg_r) * SUM_W'(M_ZG)
           + SUM_W'(lb_r) * SUM_W'(M_ZB);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lr_r <= LIN_TBL[red];
      lg_r <= LIN_TBL[green];
      lb_r <= LIN_TBL[blue];
      sx_r <= sx_nxt;
      sy_r <= sy_nxt;
      sz_r <= sz_nxt;
    end
  end

  assign out_valid = v2_r;
  assign sx = sx_r;
  assign sy = sy_r;
  assign sz = sz_r;
endmodule
`default_nettype wire

[design/s2lab_norm.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// s2lab_norm
// Divide X, Y, Z by the white point with rounding, by reciprocal multiply
// and a remainder correction. Four stages.
// ----------------------------------------------------------------------------
module s2lab_norm (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                en,
  input  wire                in_valid,
  input  s2lab_pkg::sum_t    sx,
  input  s2lab_pkg::sum_t    sy,
  input  s2lab_pkg::sum_t    sz,
  output logic               out_valid,
  output s2lab_pkg::nrm_t    xn,
  output s2lab_pkg::nrm_t    yn,
  output s2lab_pkg::nrm_t    zn
);
  import s2lab_pkg::*;

  logic [NUM_W-1:0]  n1_r  [LANES];
  logic [NUM_W-1:0]  n2_r  [LANES];
  logic [NUM_W-1:0]  rem_r [LANES];
  nrm_t              qe_r  [LANES];
  nrm_t              qe3_r [LANES];
  nrm_t              q_r   [LANES];
  logic [NUM_W-1:0]  n1_nxt  [LANES];
  nrm_t              qe_nxt  [LANES];
  logic [NUM_W-1:0]  rem_nxt [LANES];
  nrm_t              q_nxt   [LANES];
  logic [3:0]        v_r;

  always_comb begin
    logic [NUM_W-1:0] nh;
    logic [NUM_W-1:0] d;
    n1_nxt[0] = NUM_W'(sx) * NUM_W'(10) + NUM_W'(HALF_X);
    n1_nxt[1] = NUM_W'(sy) + NUM_W'(HALF_Y);
    n1_nxt[2] = NUM_W'(sz) * NUM_W'(10) + NUM_W'(HALF_Z);
    for (int k = 0; k < LANES; k++) begin
      nh         = n1_r[k] >> DROP_NRM[k];
      qe_nxt[k]  = NRM_W'((64'(nh[NRM_W-1:0]) * 64'(RCP_NRM[k])) >> 32);
      d          = NUM_W'(DIV_NRM[k]);
      rem_nxt[k] = n2_r[k] - NUM_W'(qe_r[k]) * d;
      if (rem_r[k] >= (d << 1))  q_nxt[k] = qe3_r[k] + NRM_W'(2);
      else if (rem_r[k] >= d)    q_nxt[k] = qe3_r[k] + NRM_W'(1);
      else                       q_nxt[k] = qe3_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < LANES; k++) begin
        n1_r[k]  <= n1_nxt[k];
        n2_r[k]  <= n1_r[k];
        qe_r[k]  <= qe_nxt[k];
        rem_r[k] <= rem_nxt[k];
        qe3_r[k] <= qe_r[k];
        q_r[k]   <= q_nxt[k];
      end
    end
  end

  assign out_valid = v_r[3];
  assign xn = q_r[0];
  assign yn = q_r[1];
  assign zn = q_r[2];
endmodule
`default_nettype wire

[design/s2lab_labf.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// s2lab_labf
// CIELAB f(t) for one component: a 17-stage cube root, one result bit per
// stage, with the linear toe computed alongside. 18 stages in all.
// ----------------------------------------------------------------------------
module s2lab_labf (
  input  wire                clk,
  input  wire                en,
  input  s2lab_pkg::nrm_t    t,
  output s2lab_pkg::f_t      f
);
  import s2lab_pkg::*;

  localparam int CB_N     = F_W;
  localparam int TGT_W    = 52;
  localparam int R2_W     = 35;
  localparam int TOE_DONE = 3;

  logic [TGT_W-1:0]  tg_r  [CB_N];
  f_t                r_r   [CB_N];
  logic [R2_W-1:0]   r2_r  [CB_N];
  logic [TGT_W-1:0]  r3_r  [CB_N];
  logic              toe_r [CB_N];
  f_t                r_nxt  [CB_N];
  logic [R2_W-1:0]   r2_nxt [CB_N];
  logic [TGT_W-1:0]  r3_nxt [CB_N];

  logic [TN_W-1:0]   tn_r, tn1_r, trm_r;
  f_t                tqe_r, tqe2_r;
  f_t                tf_r [TOE_DONE:CB_N-1];
  f_t                tqe_nxt, tf_nxt;
  logic [TN_W-1:0]   trm_nxt;
  f_t                f_r;

  // One cube-root bit per stage: try r + 2^b and keep it if its cube fits
  always_comb begin
    f_t               pr;
    logic [R2_W-1:0]  pr2;
    logic [TGT_W-1:0] pr3, ptg, c3;
    for (int i = 0; i < CB_N; i++) begin
      if (i == 0) begin
        pr  = '0;
        pr2 = '0;
        pr3 = '0;
        ptg = TGT_W'(t) << 24;
      end else begin
        pr  = r_r[i-1];
        pr2 = r2_r[i-1];
        pr3 = r3_r[i-1];
        ptg = tg_r[i-1];
      end
      c3 = pr3 + (((TGT_W'(pr2) << 1) + TGT_W'(pr2)) << (CB_N - 1 - i))
               + (((TGT_W'(pr) << 1) + TGT_W'(pr)) << (2 * (CB_N - 1 - i)))
               + (TGT_W'(1) << (3 * (CB_N - 1 - i)));
      if (c3 <= ptg) begin
        r_nxt[i]  = pr | (F_W'(1) << (CB_N - 1 - i));
        r2_nxt[i] = pr2 + (R2_W'(pr) << (CB_N - i))
                        + (R2_W'(1) << (2 * (CB_N - 1 - i)));
        r3_nxt[i] = c3;
      end else begin
        r_nxt[i]  = pr;
        r2_nxt[i] = pr2;
        r3_nxt[i] = pr3;
      end
    end
  end

  // Toe: floor(n / D) by reciprocal estimate and remainder correction
  always_comb begin
    logic [TN_W-1:0] nh;
    nh      = tn_r >> DROP_F;
    tqe_nxt = F_W'((64'(nh) * 64'(RCP_F)) >> 32);
    trm_nxt = tn1_r - TN_W'(tqe_r) * TN_W'(DIV_F);
    if (trm_r >= (TN_W'(DIV_F) << 1)) tf_nxt = tqe2_r + F_W'(2);
    else if (trm_r >= TN_W'(DIV_F))   tf_nxt = tqe2_r + F_W'(1);
    else                              tf_nxt = tqe2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < CB_N; i++) begin
        r_r[i]  <= r_nxt[i];
        r2_r[i] <= r2_nxt[i];
        r3_r[i] <= r3_nxt[i];
        if (i == 0) begin
          tg_r[i]  <= TGT_W'(t) << 24;
          toe_r[i] <= (t <= T_TOE);
        end else begin
          tg_r[i]  <= tg_r[i-1];
          toe_r[i] <= toe_r[i-1];
        end
      end
      tn_r   <= TN_W'(F_SLOPE) * TN_W'(t[17:0]) + F_OFS;
      tn1_r  <= tn_r;
      tqe_r  <= tqe_nxt;
      trm_r  <= trm_nxt;
      tqe2_r <= tqe_r;
      tf_r[TOE_DONE] <= tf_nxt;
      for (int i = TOE_DONE + 1; i < CB_N; i++) tf_r[i] <= tf_r[i-1];
      f_r <= toe_r[CB_N-1] ? tf_r[CB_N-1] : r_r[CB_N-1];
    end
  end

  assign f = f_r;
endmodule
`default_nettype wire

[design/s2lab_out.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// s2lab_out
// Form L, a, b from the f values, round to the output format and saturate.
// Two stages; the second is the output register.
// ----------------------------------------------------------------------------
module s2lab_out (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 en,
  input  wire                 in_valid,
  input  s2lab_pkg::f_t       fx,
  input  s2lab_pkg::f_t       fy,
  input  s2lab_pkg::f_t       fz,
  output logic                out_valid,
  output s2lab_pkg::light_t   lightness,
  output s2lab_pkg::ab_t      green_red,
  output s2lab_pkg::ab_t      blue_yellow
);
  import s2lab_pkg::*;

  localparam logic signed [RAW_W-1:0] RND_HALF = RAW_W'(1) <<< (RND_SH - 1);
  localparam logic signed [RAW_W-1:0] L_OFS    = RAW_W'(16 * 65536);

  logic signed [RAW_W-1:0] l_r, a_r, b_r;
  logic signed [RAW_W-1:0] l_nxt, a_nxt, b_nxt;
  logic signed [RAW_W-1:0] lq, aq, bq;
  logic                    v1_r, v2_r;
  light_t                  lo_r;
  ab_t                     ao_r, bo_r;
  light_t                  lo_nxt;
  ab_t                     ao_nxt, bo_nxt;

  // Round half away from zero
  function automatic logic signed [RAW_W-1:0] rnd(input logic signed [RAW_W-1:0] v);
    logic signed [RAW_W-1:0] m;
    m = -v;
    if (v >= 0) return (v + RND_HALF) >>> RND_SH;
    return -((m + RND_HALF) >>> RND_SH);
  endfunction

  function automatic ab_t sat_ab(input logic signed [RAW_W-1:0] v);
    if (v < -RAW_W'(32768)) return ab_t'(16'sh8000);
    if (v > RAW_W'(32767))  return ab_t'(16'sh7fff);
    return AB_W'(v);
  endfunction

  always_comb begin
    l_nxt = $signed({{(RAW_W-F_W){1'b0}}, fy}) * RAW_W'(116) - L_OFS;
    a_nxt = ($signed({{(RAW_W-F_W){1'b0}}, fx}) - $signed({{(RAW_W-F_W){1'b0}}, fy}))
            * RAW_W'(500);
    b_nxt = ($signed({{(RAW_W-F_W){1'b0}}, fy}) - $signed({{(RAW_W-F_W){1'b0}}, fz}))
            * RAW_W'(200);
    lq = rnd(l_r);
    aq = rnd(a_r);
    bq = rnd(b_r);
    if (lq < 0)                          lo_nxt = '0;
    else if (lq > $signed(RAW_W'(LIGHT_CAP))) lo_nxt = LIGHT_CAP;
    else                                 lo_nxt = L_W'(lq);
    ao_nxt = sat_ab(aq);
    bo_nxt = sat_ab(bq);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l_r  <= l_nxt;
      a_r  <= a_nxt;
      b_r  <= b_nxt;
      lo_r <= lo_nxt;
      ao_r <= ao_nxt;
      bo_r <= bo_nxt;
    end
  end

  assign out_valid   = v2_r;
  assign lightness   = lo_r;
  assign green_red   = ao_r;
  assign blue_yellow = bo_r;
endmodule
`default_nettype wire

[design/srgb_to_cielab_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// srgb_to_cielab_top
// 8-bit sRGB pixel to CIELAB (D65 white), fixed point, fully pipelined.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                  | handshake
//  in_ch    | in  | red, green, blue (8 b each)              | valid/ready
//  out_ch   | out | lightness (15 b), green_red, blue_yellow | valid/ready
//
//  The pipeline runs gamma decode and the matrix, the white-point divide,
//  f(t) (one cube-root bit per stage), then L/a/b rounding and saturation.
//  One pixel enters per cycle unless a finished result waits on out_ch.
//  Reset (synchronous, active low) clears only the valid bits.
//  A stall on out_ch freezes the whole pipeline; nothing is dropped.
// ----------------------------------------------------------------------------
module srgb_to_cielab_top (
  input  wire           clk,
  input  wire           rst_n,
  s2lab_pix_if.sink     in_ch,
  s2lab_lab_if.source   out_ch
);
  import s2lab_pkg::*;

  localparam int LF_LAT = F_W + 1;

  logic               en;
  logic               xyz_v, nrm_v;
  sum_t               sx, sy, sz;
  nrm_t               xn, yn, zn;
  f_t                 fx, fy, fz;
  logic [LF_LAT-1:0]  lf_v_r;

  // Advance everything unless a finished result is being held
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  s2lab_linxyz u_linxyz (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_ch.valid),
    .red       (in_ch.red),
    .green     (in_ch.green),
    .blue      (in_ch.blue),
    .out_valid (xyz_v),
    .sx        (sx),
    .sy        (sy),
    .sz        (sz)
  );

  s2lab_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (xyz_v),
    .sx        (sx),
    .sy        (sy),
    .sz        (sz),
    .out_valid (nrm_v),
    .xn        (xn),
    .yn        (yn),
    .zn        (zn)
  );

  // Three f(t) lanes run in lock step; one valid line tracks them
  s2lab_labf u_labf_x (.clk(clk), .en(en), .t(xn), .f(fx));
  s2lab_labf u_labf_y (.clk(clk), .en(en), .t(yn), .f(fy));
  s2lab_labf u_labf_z (.clk(clk), .en(en), .t(zn), .f(fz));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lf_v_r <= '0;
    end else if (en) begin
      lf_v_r <= {lf_v_r[LF_LAT-2:0], nrm_v};
    end
  end

  s2lab_out u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (lf_v_r[LF_LAT-1]),
    .fx          (fx),
    .fy          (fy),
    .fz          (fz),
    .out_valid   (out_ch.valid),
    .lightness   (out_ch.lightness),
    .green_red   (out_ch.green_red),
    .blue_yellow (out_ch.blue_yellow)
  );

  // Nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");

  // A held result freezes the f(t) section
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> $stable(lf_v_r))
    else $error("pipeline moved during output stall");

  // Lightness never passes its ceiling
  a_light_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.lightness <= LIGHT_CAP))
    else $error("lightness above ceiling");

endmodule
`default_nettype wire

[tb/srgb_to_cielab_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srgb_to_cielab_checker
// Watches the pixel and Lab channels, predicts each Lab triple from the
// accepted pixel with an exact fixed-point model and compares in order.
// ----------------------------------------------------------------------------
module srgb_to_cielab_checker (
  input  wire          clk,
  input  wire          rst_n,
  s2lab_pix_if.sink    pix,
  s2lab_lab_if.sink    lab,
  output int           fail_count,
  output int           pending
);
  import s2lab_pkg::*;

  typedef struct packed {
    light_t lightness;
    ab_t    green_red;
    ab_t    blue_yellow;
  } lab_triple_t;

  lab_triple_t lab_queue[$];
  longint unsigned lin_of_code [256];

  function automatic longint unsigned decode_gamma(int c);
    longint unsigned t, t2, lo, hi, mid, p;
    if (c <= 10) return (64'(c) * 64'd1677721600 + 64'd164730) / 64'd329460;
    t  = ((64'd1000 * 64'(c) + 64'd14025) * 64'd16777216 + 64'd134512) / 64'd269025;
    t2 = (t * t) >> 24;
    lo = 0;
    hi = 64'd16777216;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      p = mid;
      repeat (4) p = (p * mid) >> 24;
      if (p <= t2) lo = mid;
      else hi = mid - 1;
    end
    return (t2 * lo) >> 24;
  endfunction

  function automatic longint lab_curve(longint unsigned t);
    longint unsigned tgt, lo, hi, mid;
    if (t * 64'd1000000 > (64'd8856 << 24)) begin
      tgt = t << 24;
      lo = 0;
      hi = 131072;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        if (mid * mid * mid <= tgt) lo = mid;
        else hi = mid - 1;
      end
      return longint'(lo);
    end
    return longint'((64'd903292 * t + 64'd16000 * 64'd16777216 + 64'd14848000)
                    / 64'd29696000);
  endfunction

  function automatic longint shift_round(longint v, int s);
    longint half;
    half = 64'sd1 <<< (s - 1);
    if (v >= 0) return (v + half) >>> s;
    return -(((-v) + half) >>> s);
  endfunction

  function automatic longint sat(longint v, longint lo, longint hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic lab_triple_t convert_pixel(ch_t r, ch_t g, ch_t b);
    longint unsigned lr, lg, lb, sx, sy, sz;
    longint fx, fy, fz, l, a, bb, cap;
    lab_triple_t res;
    lr = lin_of_code[r];
    lg = lin_of_code[g];
    lb = lin_of_code[b];
    sx = 4124 * lr + 3576 * lg + 1805 * lb;
    sy = 2126 * lr + 7152 * lg + 722 * lb;
    sz = 193 * lr + 1192 * lg + 9505 * lb;
    fx = lab_curve((sx * 10 + 47523) / 95047);
    fy = lab_curve((sy + 5000) / 10000);
    fz = lab_curve((sz * 10 + 54441) / 108883);
    cap = 64'sd100 <<< OUT_FRAC_BITS;
    if (cap > 32767) cap = 32767;
    l  = sat(shift_round(116 * fy - 16 * 65536, 16 - OUT_FRAC_BITS), 0, cap);
    a  = sat(shift_round(500 * (fx - fy), 16 - OUT_FRAC_BITS), -32768, 32767);
    bb = sat(shift_round(200 * (fy - fz), 16 - OUT_FRAC_BITS), -32768, 32767);
    res.lightness   = light_t'(l);
    res.green_red   = ab_t'(a);
    res.blue_yellow = ab_t'(bb);
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    for (int c = 0; c < 256; c++) lin_of_code[c] = decode_gamma(c);
  end

  always @(posedge clk) begin
    lab_triple_t want;
    if (rst_n) begin
      if (pix.valid && pix.ready)
        lab_queue.push_back(convert_pixel(pix.red, pix.green, pix.blue));
      if (lab.valid && lab.ready) begin
        if (lab_queue.size() == 0) begin
          report_mismatch("unexpected item", 0, 0);
        end else begin
          want = lab_queue.pop_front();
          if (lab.lightness !== want.lightness)
            report_mismatch("lightness", lab.lightness, want.lightness);
          if (lab.green_red !== want.green_red)
            report_mismatch("green_red", lab.green_red, want.green_red);
          if (lab.blue_yellow !== want.blue_yellow)
            report_mismatch("blue_yellow", lab.blue_yellow, want.blue_yellow);
        end
      end
    end
    pending = lab_queue.size();
  end
endmodule

[tb/srgb_to_cielab_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srgb_to_cielab_top_tb
// Drives directed and random sRGB pixels with random gaps and result-side
// stalls, including one long stall that backs up the pipeline; the checker
// predicts every Lab triple and this bench gives the verdict.
// ----------------------------------------------------------------------------
module srgb_to_cielab_top_tb;
  import s2lab_pkg::*;

  localparam int RANDOM_PIXELS = 2000;
  localparam int LONG_STALL    = 200;
  localparam int CYCLE_LIMIT   = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, pending, cycles = 0;
  bit   sending_done = 1'b0;
  bit   hold_results = 1'b0;

  s2lab_pix_if pix_ch();
  s2lab_lab_if lab_ch();

  srgb_to_cielab_top u_dut (.clk(clk), .rst_n(rst_n), .in_ch(pix_ch), .out_ch(lab_ch));

  srgb_to_cielab_checker u_checker (
    .clk(clk), .rst_n(rst_n), .pix(pix_ch), .lab(lab_ch),
    .fail_count(fail_count), .pending(pending));

  always #5 clk = ~clk;

  // Count cycles and bail out on a hang
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Send one pixel: wait out a random gap, then hold until accepted
  task automatic send_pixel(ch_t r, ch_t g, ch_t b);
    int gap;
    gap = $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) begin
      pix_ch.valid <= 1'b0;
      @(negedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.red   <= r;
    pix_ch.green <= g;
    pix_ch.blue  <= b;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Random pixel: bias toward the toe codes and the top end now and then
  function automatic ch_t pick_code();
    case ($urandom_range(0, 5))
      0:       return ch_t'($urandom_range(0, 12));
      1:       return ch_t'($urandom_range(243, 255));
      default: return ch_t'($urandom);
    endcase
  endfunction

  // Stimulus
  initial begin
    ch_t corners [6];
    corners = '{8'd0, 8'd10, 8'd11, 8'd128, 8'd254, 8'd255};
    pix_ch.valid = 1'b0;
    pix_ch.red = '0;
    pix_ch.green = '0;
    pix_ch.blue = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // Directed: black, white, primaries, secondaries, corner-code mixes, the gamma toe edge
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd1, 8'd1, 8'd1);
    for (int i = 0; i < 6; i++)
      send_pixel(corners[i], corners[(i + 2) % 6], corners[(i + 4) % 6]);
    send_pixel(8'd10, 8'd10, 8'd10);
    send_pixel(8'd11, 8'd11, 8'd11);
    send_pixel(8'd0, 8'd1, 8'd0);
    send_pixel(8'd170, 8'd85, 8'd51);
    // Random part
    for (int i = 0; i < RANDOM_PIXELS; i++)
      send_pixel(pick_code(), pick_code(), pick_code());
    pix_ch.valid <= 1'b0;
    sending_done = 1'b1;
  end

  // Long hold-off on the result side, early in the random part
  initial begin
    repeat (300) @(negedge clk);
    hold_results = 1'b1;
    repeat (LONG_STALL) @(negedge clk);
    hold_results = 1'b0;
  end

  // Result-side ready: a random stall before each item is taken
  initial begin
    int stall;
    lab_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        lab_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      while (hold_results) begin
        lab_ch.ready <= 1'b0;
        @(negedge clk);
      end
      lab_ch.ready <= 1'b1;
      @(posedge clk);
      while (!lab_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Verdict: drain, then let the pipeline settle to catch stray items
  initial begin
    wait (sending_done);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule

[sim.f]
design/s2lab_pkg.sv
design/s2lab_pix_if.sv
design/s2lab_lab_if.sv
design/s2lab_linxyz.sv
design/s2lab_norm.sv
design/s2lab_labf.sv
design/s2lab_out.sv
design/srgb_to_cielab_top.sv
tb/srgb_to_cielab_checker.sv
tb/srgb_to_cielab_top_tb.sv
